// File: rtl/llmc_pkg.sv
// llmc_pkg: shared types, register codes, constants and byte helpers for the
// line literal match counter. No dependencies.
`timescale 1ns / 1ps

package llmc_pkg;

  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned PATTERN_BYTES = 32;
  localparam int unsigned PATTERN_W     = PATTERN_BYTES * 8;
  localparam int unsigned CNT_W         = 16;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 16'hFFFF;
  localparam logic [7:0]       NL_BYTE     = 8'h0A;
  localparam logic [7:0]       NUL_BYTE    = 8'h00;
  localparam logic [7:0]       UPPER_A     = 8'h41;
  localparam logic [7:0]       UPPER_Z     = 8'h5A;
  localparam logic [7:0]       CASE_OFFSET = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_LENGTH = 3'd0,
    REG_PATTERN_WORD_0 = 3'd1,
    REG_PATTERN_WORD_1 = 3'd2,
    REG_PATTERN_WORD_2 = 3'd3,
    REG_PATTERN_WORD_3 = 3'd4,
    REG_FOLD_CASE      = 3'd5,
    REG_TALLY_ONLY     = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    FUNC_DATA = 1'b0,
    FUNC_END  = 1'b1
  } func_e;

  typedef struct packed {
    logic [LEN_W-1:0]     pattern_length;
    logic [PATTERN_W-1:0] pattern;
    logic                 fold_case;
    logic                 tally_only;
  } cfg_t;

  // what the matcher tells the tally about the beat at hand
  typedef struct packed {
    logic close;
    logic matched;
    logic end_of_data;
  } close_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] match_total;
    logic             is_count_report;
  } result_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && (c inside {[UPPER_A:UPPER_Z]})) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  // bytes past the pattern registers read as zero
  function automatic logic [7:0] pattern_byte(input logic [PATTERN_W-1:0] p,
                                              input logic [LEN_W-1:0] idx);
    logic [7:0] r;
    r = 8'h00;
    if (!idx[LEN_W-1]) begin
      r = p[{idx[LEN_W-2:0], 3'b000} +: 8];
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == COUNT_LIMIT) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/llmc_if.sv
// llmc_if: valid/ready channel interfaces for input beats, result beats and
// configuration writes. Depends on llmc_pkg.
`timescale 1ns / 1ps

interface llmc_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink   (input valid, input func, input data_byte, output ready);
endinterface

interface llmc_out_if;
  logic                        valid;
  logic                        ready;
  logic [llmc_pkg::CNT_W-1:0]  line_number;
  logic [llmc_pkg::CNT_W-1:0]  match_total;
  logic                        is_count_report;

  modport source (output valid, output line_number, output match_total,
                  output is_count_report, input ready);
  modport sink   (input valid, input line_number, input match_total,
                  input is_count_report, output ready);
endinterface

interface llmc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [llmc_pkg::CFG_IDX_W-1:0]    index;
  logic [llmc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/line_literal_match_counter.sv
// line_literal_match_counter: top level, input register, matcher, tally and
// result register. Depends on llmc_pkg, llmc_if and the llmc_* modules.
`timescale 1ns / 1ps

//  channel  | dir | payload                                       | accepted when
//  in_i     | in  | func, data_byte                               | valid && ready
//  out_o    | out | line_number, match_total, is_count_report     | valid && ready
//  cfg_i    | in  | index (register number), data                 | valid && ready
//
// one beat per cycle sustained while no result is stalled; a beat taken into
// the input register is worked on from there and its result passes through
// the result register; the window compare over all positions is combinational
// reset clears the window, counters and configuration at once, no sweep
// a stalled result holds; one further beat is still taken into the input
// register, after which ready drops until the result leaves

module line_literal_match_counter #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned MAX_LINE    = 511
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  llmc_in_if.sink    in_i,
  llmc_out_if.source out_o,
  llmc_cfg_if.sink   cfg_i
);

  llmc_pkg::cfg_t    cfg;
  llmc_pkg::close_t  close_info;
  llmc_pkg::result_t result;

  logic       s1_valid_q, s1_valid_d;
  logic       s1_func_q;
  logic [7:0] s1_byte_q;
  logic       step;

  logic                        out_valid_q, out_valid_d;
  logic [llmc_pkg::CNT_W-1:0]  out_line_q, out_match_q;
  logic                        out_is_count_q;

  assign step       = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || step;

  assign s1_valid_d  = in_i.ready ? in_i.valid : s1_valid_q;
  assign out_valid_d = step ? result.valid : (out_valid_q && !out_o.ready);

  llmc_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  llmc_matcher #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_LINE    (MAX_LINE)
  ) u_matcher (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .func_i      (s1_func_q),
    .data_byte_i (s1_byte_q),
    .cfg_i       (cfg),
    .close_o     (close_info)
  );

  llmc_tally u_tally (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .close_i      (close_info),
    .tally_only_i (cfg.tally_only),
    .result_o     (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_func_q <= in_i.func;
      s1_byte_q <= in_i.data_byte;
    end
    if (step && result.valid) begin
      out_line_q     <= result.line_number;
      out_match_q    <= result.match_total;
      out_is_count_q <= result.is_count_report;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.line_number     = out_line_q;
  assign out_o.match_total     = out_match_q;
  assign out_o.is_count_report = out_is_count_q;

`ifndef SYNTHESIS
  // matches can never outrun lines
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.match_total <= out_o.line_number))
    else $error("match count above line number");

  // a byte that does not close a line leaves the result slot empty
  a_no_result_mid_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !close_info.close) |=> !out_valid_q)
    else $error("result raised for a byte inside a line");

  // end of data in count mode always reports
  a_count_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && close_info.end_of_data && cfg.tally_only) |=>
      (out_valid_q && out_is_count_q))
    else $error("count report missing at end of data");
`endif

endmodule

// File: rtl/llmc_cfg_regs.sv
// llmc_cfg_regs: configuration register file, written one beat at a time.
// Depends on llmc_pkg and llmc_if.
`timescale 1ns / 1ps

module llmc_cfg_regs (
  input  logic               clk_i,
  input  logic               rst_ni,
  llmc_cfg_if.sink           cfg_i,
  output llmc_pkg::cfg_t     cfg_o
);

  llmc_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (llmc_pkg::cfg_reg_e'(cfg_i.index))
        llmc_pkg::REG_PATTERN_LENGTH:
          cfg_d.pattern_length = cfg_i.data[llmc_pkg::LEN_W-1:0];
        llmc_pkg::REG_PATTERN_WORD_0: cfg_d.pattern[63:0]    = cfg_i.data;
        llmc_pkg::REG_PATTERN_WORD_1: cfg_d.pattern[127:64]  = cfg_i.data;
        llmc_pkg::REG_PATTERN_WORD_2: cfg_d.pattern[191:128] = cfg_i.data;
        llmc_pkg::REG_PATTERN_WORD_3: cfg_d.pattern[255:192] = cfg_i.data;
        llmc_pkg::REG_FOLD_CASE:      cfg_d.fold_case        = cfg_i.data[0];
        llmc_pkg::REG_TALLY_ONLY:     cfg_d.tally_only       = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/llmc_matcher.sv
// llmc_matcher: per-line window of recent bytes, kept-byte count and the
// parallel pattern compare. Depends on llmc_pkg.
`timescale 1ns / 1ps

module llmc_matcher #(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned MAX_LINE    = 511
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic                 func_i,
  input  logic [7:0]           data_byte_i,
  input  llmc_pkg::cfg_t       cfg_i,
  output llmc_pkg::close_t     close_o
);

  localparam int unsigned KEPT_W = $clog2(MAX_LINE + 1);
  localparam int unsigned ALEN_W = $clog2(MAX_PATTERN + 1);
  localparam int unsigned WIDE_W = llmc_pkg::LEN_W + 1;

  logic [7:0]        recent_q [MAX_PATTERN];
  logic [7:0]        recent_d [MAX_PATTERN];
  logic [7:0]        win_new  [MAX_PATTERN];
  logic [KEPT_W-1:0] kept_q, kept_d, kept_new;
  logic              lhm_q, lhm_d;
  logic [ALEN_W-1:0] alen;
  logic [MAX_PATTERN-1:0] pos_ok;
  logic              window_hit;
  logic              is_end, is_term, can_keep;

  assign is_end   = (llmc_pkg::func_e'(func_i) == llmc_pkg::FUNC_END);
  assign is_term  = (data_byte_i == llmc_pkg::NL_BYTE) ||
                    (data_byte_i == llmc_pkg::NUL_BYTE);
  assign can_keep = (kept_q < KEPT_W'(MAX_LINE));
  assign kept_new = kept_q + KEPT_W'(1);

  // length in use, clamped to the window depth
  always_comb begin
    if (WIDE_W'(cfg_i.pattern_length) > WIDE_W'(MAX_PATTERN)) begin
      alen = ALEN_W'(MAX_PATTERN);
    end else begin
      alen = ALEN_W'(cfg_i.pattern_length);
    end
  end

  // window after the shift, newest byte at position 0
  always_comb begin
    win_new[0] = data_byte_i;
    for (int j = 1; j < MAX_PATTERN; j++) begin
      win_new[j] = recent_q[j-1];
    end
  end

  // window position j lines up with pattern byte alen-1-j
  always_comb begin
    logic [WIDE_W-1:0] pidx;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      pidx = WIDE_W'(alen) - WIDE_W'(1) - WIDE_W'(j);
      pos_ok[j] = (32'(j) >= 32'(alen)) ||
                  (llmc_pkg::fold(win_new[j], cfg_i.fold_case) ==
                   llmc_pkg::fold(llmc_pkg::pattern_byte(cfg_i.pattern,
                                    pidx[llmc_pkg::LEN_W-1:0]),
                                  cfg_i.fold_case));
    end
  end

  assign window_hit = (&pos_ok) && (alen != '0) && (32'(kept_new) >= 32'(alen));

  always_comb begin
    recent_d = recent_q;
    kept_d   = kept_q;
    lhm_d    = lhm_q;
    if (step_i) begin
      if (is_end || is_term) begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
          recent_d[j] = 8'h00;
        end
        kept_d = '0;
        lhm_d  = 1'b0;
      end else if (can_keep) begin
        recent_d = win_new;
        kept_d   = kept_new;
        lhm_d    = lhm_q | window_hit;
      end
    end
  end

  assign close_o.close       = is_end || is_term;
  assign close_o.matched     = lhm_q || ((alen == '0) && (kept_q != '0));
  assign close_o.end_of_data = is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < MAX_PATTERN; j++) begin
        recent_q[j] <= 8'h00;
      end
      kept_q <= '0;
      lhm_q  <= 1'b0;
    end else begin
      recent_q <= recent_d;
      kept_q   <= kept_d;
      lhm_q    <= lhm_d;
    end
  end

endmodule

// File: rtl/llmc_tally.sv
// llmc_tally: saturating line and match counters of the stream and the
// result that a closed line or end of data gives. Depends on llmc_pkg.
`timescale 1ns / 1ps

module llmc_tally (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  llmc_pkg::close_t     close_i,
  input  logic                 tally_only_i,
  output llmc_pkg::result_t    result_o
);

  logic [llmc_pkg::CNT_W-1:0] lines_q, lines_d, lines_inc;
  logic [llmc_pkg::CNT_W-1:0] matches_q, matches_d, matches_inc;

  assign lines_inc   = llmc_pkg::sat_inc(lines_q);
  assign matches_inc = close_i.matched ? llmc_pkg::sat_inc(matches_q) : matches_q;

  always_comb begin
    result_o.line_number     = lines_inc;
    result_o.match_total     = matches_inc;
    result_o.is_count_report = close_i.end_of_data && tally_only_i;
    result_o.valid           = close_i.close &&
                               ((close_i.matched && !tally_only_i) ||
                                (close_i.end_of_data && tally_only_i));
  end

  always_comb begin
    lines_d   = lines_q;
    matches_d = matches_q;
    if (step_i && close_i.close) begin
      if (close_i.end_of_data) begin
        // end of data starts a fresh stream
        lines_d   = '0;
        matches_d = '0;
      end else begin
        lines_d   = lines_inc;
        matches_d = matches_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lines_q   <= '0;
      matches_q <= '0;
    end else begin
      lines_q   <= lines_d;
      matches_q <= matches_d;
    end
  end

endmodule
